// File: design/gwwlb_pkg.sv
// Shared types and constants for the greedy word-wrap line breaker.
// Holds field widths, character codes, register indexes and the control structs.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gwwlb_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned GLYPH_W    = 8;
  localparam int unsigned WRAP_W     = 12;
  localparam int unsigned LPP_W      = 8;
  localparam int unsigned CUR_W      = 16;
  localparam int unsigned PEN_W      = 16;
  localparam int unsigned LS_W       = 17;
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned CLO_W      = 7;
  localparam int unsigned TOT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  localparam logic [WRAP_W-1:0] WRAP_RST = 12'd314;
  localparam logic [LPP_W-1:0]  LPP_RST  = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_WIDTH      = 2'd0,
    CFG_LINES_PER_PAGE  = 2'd1,
    CFG_CURSOR_POSITION = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic take;
    logic nl_line;
    logic fin;
    logic cl_latch;
    logic div_step;
    logic rd_prev;
    logic rd_next;
    logic rd_page;
    logic cap_prev;
    logic cap_next;
    logic cap_page;
    logic load_out;
    logic run_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic need_second;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: design/greedy_word_wrap_line_breaker_top.sv
// Top level of the greedy word-wrap line breaker.
// Instantiates gwwlb_ctrl and gwwlb_dp; depends on gwwlb_pkg.
//
// Characters arrive one per beat with their pixel widths and are laid out by
// greedy word wrap; the item marked last yields one result beat with the
// cursor's line, its neighbouring line starts, its page start and the line
// count. A newline that ends a word which itself wraps takes a second step,
// because the line-start memory has one write port. After the last item the
// input is stalled while the block settles the final word, latches the
// cursor line, finds the page with a bit-serial remainder unit that works
// through the line number bit by bit, and makes three reads through the
// single read port of the line-start memory. The result waits in an output
// register, and the next text may start while it is still held.
`timescale 1ns / 1ps
`default_nettype none

module greedy_word_wrap_line_breaker_top #(
  parameter int unsigned MAX_LINES  = 128,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gwwlb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gwwlb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [gwwlb_pkg::CHAR_W-1:0]        character_i,
  input  logic [gwwlb_pkg::GLYPH_W-1:0]       glyph_width_i,
  input  logic                                end_only_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gwwlb_pkg::LS_W-1:0]   prev_line_start_o,
  output logic signed [gwwlb_pkg::LS_W-1:0]   next_line_start_o,
  output logic [gwwlb_pkg::PAGE_W-1:0]        page_start_o,
  output logic [gwwlb_pkg::CLO_W-1:0]         cursor_line_o,
  output logic [gwwlb_pkg::TOT_W-1:0]         line_total_o
);
  import gwwlb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  gwwlb_ctrl #(
    .MAX_LINES (MAX_LINES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  gwwlb_dp #(
    .MAX_LINES  (MAX_LINES),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .character_i       (character_i),
    .glyph_width_i     (glyph_width_i),
    .end_only_i        (end_only_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .prev_line_start_o (prev_line_start_o),
    .next_line_start_o (next_line_start_o),
    .page_start_o      (page_start_o),
    .cursor_line_o     (cursor_line_o),
    .line_total_o      (line_total_o)
  );

endmodule

`default_nettype wire

// File: design/gwwlb_ctrl.sv
// Controller of the line breaker: sequences item beats, the end-of-text phases
// and the result beat. Depends on gwwlb_pkg; drives gwwlb_dp by command struct.
`timescale 1ns / 1ps
`default_nettype none

module gwwlb_ctrl #(
  parameter int unsigned MAX_LINES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  input  logic              out_stall_i,
  input  gwwlb_pkg::dp_sts_t sts_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output gwwlb_pkg::dp_cmd_t cmd_o
);
  import gwwlb_pkg::*;

  localparam int unsigned CL_W  = $clog2(MAX_LINES);
  localparam int unsigned CNT_W = $clog2(CL_W + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NL   = 4'd1;
  localparam logic [3:0] S_FIN  = 4'd2;
  localparam logic [3:0] S_CL   = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_RP   = 4'd5;
  localparam logic [3:0] S_RN   = 4'd6;
  localparam logic [3:0] S_RG   = 4'd7;
  localparam logic [3:0] S_RC   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic             last_q, last_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             take;
  logic             out_free;

  assign take        = (state_q == S_IDLE) && in_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.take = take;
        if (take) begin
          last_d = last_i;
          if (sts_i.need_second) begin
            state_d = S_NL;
          end else if (last_i) begin
            state_d = S_FIN;
          end
        end
      end
      S_NL: begin
        cmd_o.nl_line = 1'b1;
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d = S_CL;
      end
      S_CL: begin
        cmd_o.cl_latch = 1'b1;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(CL_W - 1)) begin
          state_d = S_RP;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_RP: begin
        cmd_o.rd_prev = 1'b1;
        state_d = S_RN;
      end
      S_RN: begin
        cmd_o.cap_prev = 1'b1;
        cmd_o.rd_next  = 1'b1;
        state_d = S_RG;
      end
      S_RG: begin
        cmd_o.cap_next = 1'b1;
        cmd_o.rd_page  = 1'b1;
        state_d = S_RC;
      end
      S_RC: begin
        cmd_o.cap_page = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.run_clear = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: design/gwwlb_dp.sv
// Datapath of the line breaker: configuration registers, layout state, the
// line-start memory, the bit-serial remainder unit and the result registers.
// Depends on gwwlb_pkg; driven by gwwlb_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module gwwlb_dp #(
  parameter int unsigned MAX_LINES  = 128,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gwwlb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gwwlb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [gwwlb_pkg::CHAR_W-1:0]        character_i,
  input  logic [gwwlb_pkg::GLYPH_W-1:0]       glyph_width_i,
  input  logic                                end_only_i,
  input  gwwlb_pkg::dp_cmd_t                  cmd_i,
  output gwwlb_pkg::dp_sts_t                  sts_o,
  output logic signed [gwwlb_pkg::LS_W-1:0]   prev_line_start_o,
  output logic signed [gwwlb_pkg::LS_W-1:0]   next_line_start_o,
  output logic [gwwlb_pkg::PAGE_W-1:0]        page_start_o,
  output logic [gwwlb_pkg::CLO_W-1:0]         cursor_line_o,
  output logic [gwwlb_pkg::TOT_W-1:0]         line_total_o
);
  import gwwlb_pkg::*;

  localparam int unsigned IW    = INDEX_BITS;
  localparam int unsigned CL_W  = $clog2(MAX_LINES);
  localparam int unsigned AW    = CL_W;
  localparam int unsigned LC_W  = $clog2(MAX_LINES + 1);
  localparam int unsigned CMP_W = (IW > CUR_W) ? IW : CUR_W;

  logic [WRAP_W-1:0] wrap_width_q;
  logic [LPP_W-1:0]  lpp_q;
  logic [CUR_W-1:0]  cursor_q;

  logic [IW-1:0]     char_index_q, char_index_d;
  logic [PEN_W-1:0]  pen_q, pen_d;
  logic [LC_W-1:0]   lc_q, lc_d;
  logic              valid_q, valid_d;
  logic [CL_W-1:0]   found_q, found_d;
  logic              in_word_q, in_word_d;
  logic [IW-1:0]     ws_q, ws_d;
  logic [PEN_W-1:0]  ww_q, ww_d;
  logic [IW-1:0]     nl_pend_q;

  logic [CL_W-1:0]   cl_q;
  logic [CL_W-1:0]   dv_sh_q;
  logic [LPP_W-1:0]  rem_q;
  logic [LS_W-1:0]   prev_q, next_q;
  logic [PAGE_W-1:0] page_q;

  logic [IW-1:0]     mem [MAX_LINES];
  logic [IW-1:0]     rd_q;
  logic              rd_zero_q;

  logic              is_nl, is_sp, is_sep, item, fw_do, wrap, lc_room;
  logic              nl_now, mark, has_next;
  logic [PEN_W:0]    pen_ww, pen_sp, ww_g;
  logic [PEN_W-1:0]  pen_fw, ww_base;
  logic [LC_W-1:0]   lc_mid;
  logic [IW-1:0]     idx_inc;
  logic [CMP_W-1:0]  cur_x, ws_x, idx_x;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [IW-1:0]     wr_data, rd_val;
  logic              rd_en;
  logic [CL_W-1:0]   cl_now, start_line;
  logic [LPP_W:0]    trial;

  always_comb begin
    is_nl   = (character_i == CH_NEWLINE);
    is_sp   = (character_i == CH_SPACE);
    is_sep  = is_nl || is_sp;
    item    = cmd_i.take && !end_only_i;
    fw_do   = in_word_q && ((item && is_sep) || cmd_i.fin);
    pen_ww  = {1'b0, pen_q} + {1'b0, ww_q};
    wrap    = fw_do && (pen_q != '0) && (pen_ww > (PEN_W + 1)'(wrap_width_q));
    lc_room = (lc_q < LC_W'(MAX_LINES));
    lc_mid  = lc_q + LC_W'(wrap && lc_room);
    nl_now  = item && is_nl && !wrap;
    idx_inc = (char_index_q == '1) ? char_index_q : char_index_q + IW'(1);

    if (!fw_do) begin
      pen_fw = pen_q;
    end else if (wrap) begin
      pen_fw = ww_q;
    end else begin
      pen_fw = pen_ww[PEN_W] ? '1 : pen_ww[PEN_W-1:0];
    end
    pen_sp  = {1'b0, pen_fw} + (PEN_W + 1)'(glyph_width_i);
    ww_base = in_word_q ? ww_q : '0;
    ww_g    = {1'b0, ww_base} + (PEN_W + 1)'(glyph_width_i);

    cur_x = CMP_W'(cursor_q);
    ws_x  = CMP_W'(ws_q);
    idx_x = CMP_W'(char_index_q);
    mark  = !valid_q && ((fw_do && (cur_x >= ws_x) && (cur_x <= idx_x)) ||
                         (item && is_sep && (idx_x >= cur_x)));

    wr_en   = ((wrap || nl_now || cmd_i.nl_line) && lc_room);
    wr_addr = lc_q[AW-1:0];
    if (wrap) begin
      wr_data = ws_q;
    end else if (cmd_i.nl_line) begin
      wr_data = nl_pend_q;
    end else begin
      wr_data = idx_inc;
    end

    sts_o.need_second = item && is_nl && wrap;

    char_index_d = char_index_q;
    pen_d        = pen_q;
    lc_d         = lc_q + LC_W'(wr_en);
    valid_d      = valid_q;
    found_d      = found_q;
    in_word_d    = in_word_q;
    ws_d         = ws_q;
    ww_d         = ww_q;

    if (mark) begin
      valid_d = 1'b1;
      found_d = CL_W'(lc_mid - LC_W'(1));
    end
    if (fw_do) begin
      pen_d     = pen_fw;
      in_word_d = 1'b0;
      ww_d      = '0;
    end
    if (item) begin
      char_index_d = idx_inc;
      if (is_nl) begin
        pen_d = '0;
      end else if (is_sp) begin
        pen_d = pen_sp[PEN_W] ? '1 : pen_sp[PEN_W-1:0];
      end else begin
        in_word_d = 1'b1;
        ws_d      = in_word_q ? ws_q : char_index_q;
        ww_d      = ww_g[PEN_W] ? '1 : ww_g[PEN_W-1:0];
      end
    end
    if (cmd_i.nl_line) begin
      pen_d = '0;
    end
    if (cmd_i.run_clear) begin
      char_index_d = '0;
      pen_d        = '0;
      lc_d         = LC_W'(1);
      valid_d      = 1'b0;
      found_d      = '0;
      in_word_d    = 1'b0;
      ws_d         = '0;
      ww_d         = '0;
    end
  end

  always_comb begin
    cl_now     = valid_q ? found_q : CL_W'(lc_q - LC_W'(1));
    trial      = {rem_q, dv_sh_q[CL_W-1]};
    start_line = (lpp_q == '0) ? '0 : cl_q - CL_W'(rem_q);
    has_next   = (LC_W'(cl_q) + LC_W'(1)) < lc_q;
    rd_en      = cmd_i.rd_prev || cmd_i.rd_next || cmd_i.rd_page;
    if (cmd_i.rd_prev) begin
      rd_addr = cl_q - CL_W'(1);
    end else if (cmd_i.rd_next) begin
      rd_addr = cl_q + CL_W'(1);
    end else begin
      rd_addr = start_line;
    end
    rd_val = rd_zero_q ? '0 : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_width_q <= WRAP_RST;
      lpp_q        <= LPP_RST;
      cursor_q     <= '0;
      char_index_q <= '0;
      pen_q        <= '0;
      lc_q         <= LC_W'(1);
      valid_q      <= 1'b0;
      found_q      <= '0;
      in_word_q    <= 1'b0;
      ws_q         <= '0;
      ww_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WRAP_WIDTH:      wrap_width_q <= cfg_wdata_i[WRAP_W-1:0];
          CFG_LINES_PER_PAGE:  lpp_q        <= cfg_wdata_i[LPP_W-1:0];
          CFG_CURSOR_POSITION: cursor_q     <= cfg_wdata_i[CUR_W-1:0];
          default: begin
          end
        endcase
      end
      char_index_q <= char_index_d;
      pen_q        <= pen_d;
      lc_q         <= lc_d;
      valid_q      <= valid_d;
      found_q      <= found_d;
      in_word_q    <= in_word_d;
      ws_q         <= ws_d;
      ww_q         <= ww_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts_o.need_second) begin
      nl_pend_q <= idx_inc;
    end
    if (cmd_i.cl_latch) begin
      cl_q    <= cl_now;
      dv_sh_q <= cl_now;
      rem_q   <= '0;
    end
    if (cmd_i.div_step) begin
      dv_sh_q <= dv_sh_q << 1;
      if (trial >= {1'b0, lpp_q}) begin
        rem_q <= LPP_W'(trial - {1'b0, lpp_q});
      end else begin
        rem_q <= trial[LPP_W-1:0];
      end
    end
    if (cmd_i.cap_prev) begin
      prev_q <= (cl_q == '0) ? '1 : LS_W'(rd_val);
    end
    if (cmd_i.cap_next) begin
      next_q <= has_next ? LS_W'(rd_val) : '1;
    end
    if (cmd_i.cap_page) begin
      page_q <= PAGE_W'(rd_val);
    end
    if (cmd_i.load_out) begin
      prev_line_start_o <= prev_q;
      next_line_start_o <= next_q;
      page_start_o      <= page_q;
      cursor_line_o     <= CLO_W'(cl_q);
      line_total_o      <= TOT_W'(lc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_zero_q <= (rd_addr == '0);
    end
  end

endmodule

`default_nettype wire

// File: design/gwwlb_chk.sv
// Port-level checker for the line breaker and the bind that attaches it.
// Depends on gwwlb_pkg and greedy_word_wrap_line_breaker_top.
`timescale 1ns / 1ps
`default_nettype none

module gwwlb_chk #(
  parameter int unsigned MAX_LINES  = 128,
  parameter int unsigned INDEX_BITS = 16
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                last_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [gwwlb_pkg::LS_W-1:0]   prev_line_start_o,
  input logic signed [gwwlb_pkg::LS_W-1:0]   next_line_start_o,
  input logic [gwwlb_pkg::PAGE_W-1:0]        page_start_o,
  input logic [gwwlb_pkg::CLO_W-1:0]         cursor_line_o,
  input logic [gwwlb_pkg::TOT_W-1:0]         line_total_o
);
  import gwwlb_pkg::*;

  localparam bit NARROW = (MAX_LINES <= 128) && (INDEX_BITS <= 16);

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input not stalled after the last beat of a text");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(page_start_o) &&
    $stable(cursor_line_o) && $stable(line_total_o))
    else $error("stalled result beat changed");

  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat appeared without a preceding busy phase");

  a_neighbours: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NARROW |->
    ((prev_line_start_o == 17'h1FFFF) == (cursor_line_o == '0)) &&
    ((next_line_start_o == 17'h1FFFF) == (({1'b0, cursor_line_o} + 8'd1) == line_total_o)))
    else $error("neighbouring line starts disagree with cursor line and count");

endmodule

bind greedy_word_wrap_line_breaker_top gwwlb_chk #(
  .MAX_LINES  (MAX_LINES),
  .INDEX_BITS (INDEX_BITS)
) u_gwwlb_chk (.*);

`default_nettype wire
